// ===== hw/rtl/tlssni_pkg.sv =====
package tlssni_pkg;

  localparam int unsigned MaxMessageBytes  = 16384;
  localparam int unsigned MaxHostnameBytes = 255;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  localparam logic [4:0] PH_IDLE    = 5'd0;
  localparam logic [4:0] PH_REC     = 5'd1;
  localparam logic [4:0] PH_HTYPE   = 5'd2;
  localparam logic [4:0] PH_HLEN    = 5'd3;
  localparam logic [4:0] PH_FIXED   = 5'd4;
  localparam logic [4:0] PH_SIDLEN  = 5'd5;
  localparam logic [4:0] PH_SIDSKIP = 5'd6;
  localparam logic [4:0] PH_CSLEN   = 5'd7;
  localparam logic [4:0] PH_CSSKIP  = 5'd8;
  localparam logic [4:0] PH_CMLEN   = 5'd9;
  localparam logic [4:0] PH_CMSKIP  = 5'd10;
  localparam logic [4:0] PH_EXTSLEN = 5'd11;
  localparam logic [4:0] PH_EXTHDR  = 5'd12;
  localparam logic [4:0] PH_EXTSKIP = 5'd13;
  localparam logic [4:0] PH_LISTLEN = 5'd14;
  localparam logic [4:0] PH_ENTHDR  = 5'd15;
  localparam logic [4:0] PH_ENTSKIP = 5'd16;
  localparam logic [4:0] PH_NAME    = 5'd17;
  localparam logic [4:0] PH_DONE    = 5'd18;

  localparam logic [7:0] RecordType    = 8'h16;
  localparam logic [7:0] HelloType     = 8'h01;
  localparam logic [6:0] MaxLabelBytes = 7'd63;
  localparam logic [15:0] FixedBytes   = 16'd34;
  localparam logic [7:0] ChDot         = 8'h2e;
  localparam logic [7:0] ChDash        = 8'h2d;

  // one result word: name byte and/or final status
  typedef struct packed {
    logic [7:0] name_length;
    logic [1:0] status;
    logic       done_res;
    logic [7:0] name_byte;
    logic       name_byte_valid;
  } res_t;

endpackage

// ===== hw/rtl/tls_client_hello_sni_extract.sv =====
// A result appears on m_axis in the cycle after the byte that causes it.
// Throughput: one byte per cycle; s_axis_tready holds while the output register
//   is empty or being taken in the same cycle.
// Parsing state is updated by one pass of logic per byte between s_axis and the
//   result register. rst (synchronous, active high) returns to idle, awaiting start.
module tls_client_hello_sni_extract #(
  parameter int unsigned MAX_MESSAGE_BYTES  = tlssni_pkg::MaxMessageBytes,
  parameter int unsigned MAX_HOSTNAME_BYTES = tlssni_pkg::MaxHostnameBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // message_length[15:0], data_byte[23:16]
  input  logic        s_axis_tuser,  // start_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // name_byte_valid, name_byte, done_res, status,
                                     // name_length, 4'b0
);
  import tlssni_pkg::*;

  logic [4:0]  phase, phase_next;
  logic [15:0] pos, pos_next, msg_end, msg_end_next, hello_end, hello_end_next;
  logic [15:0] exts_end, exts_end_next, ext_end, ext_end_next, list_end, list_end_next;
  logic [23:0] acc, acc_next;
  logic [15:0] left, left_next;
  logic        hello_short, hello_short_next, exts_short, exts_short_next;
  logic [15:0] seen, seen_next;
  logic [6:0]  label, label_next;
  logic [7:0]  prev, prev_next;
  logic        nvalid, nvalid_next;

  res_t        res, res_next;
  logic        res_vld, res_vld_next;

  logic        accept;
  logic        start;
  logic [15:0] mlen;
  logic [7:0]  b;

  assign start = s_axis_tuser;
  assign mlen  = s_axis_tdata[15:0];
  assign b     = s_axis_tdata[23:16];

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = res_vld;
  assign m_axis_tdata  = {4'b0, res.name_length, res.status, res.done_res,
                          res.name_byte, res.name_byte_valid};

  function automatic logic [15:0] left_in(input logic [15:0] e, input logic [15:0] p);
    left_in = (e > p) ? e - p : 16'd0;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    is_alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5a) ||
               (c >= 8'h61 && c <= 8'h7a);
  endfunction

  logic [15:0] p1;
  logic [23:0] sh;
  logic [15:0] dec;
  logic [15:0] r_msg, r_hello, r_exts, r_ext, r_list;
  logic [15:0] n16;
  logic [23:0] child;
  logic [7:0]  ch_len;
  logic        ch_ok;
  logic [6:0]  lab_n;
  logic        last_ok;

  always_comb begin
    phase_next = phase; pos_next = pos; msg_end_next = msg_end;
    hello_end_next = hello_end; exts_end_next = exts_end; ext_end_next = ext_end;
    list_end_next = list_end; acc_next = acc; left_next = left;
    hello_short_next = hello_short; exts_short_next = exts_short;
    seen_next = seen; label_next = label; prev_next = prev; nvalid_next = nvalid;
    res_next = '0; res_vld_next = 1'b0;

    p1      = pos + 16'd1;
    sh      = {acc[15:0], b};
    dec     = left - 16'd1;
    r_msg   = left_in(msg_end, p1);
    r_hello = left_in(hello_end, p1);
    r_exts  = left_in(exts_end, p1);
    r_ext   = left_in(ext_end, p1);
    r_list  = left_in(list_end, p1);
    n16     = sh[15:0];
    child   = 24'd0;
    ch_ok   = nvalid;
    lab_n   = label;
    last_ok = 1'b0;
    ch_len  = 8'd0;

    if (start) begin
      phase_next = PH_IDLE; pos_next = 16'd0; msg_end_next = mlen;
      hello_end_next = '0; exts_end_next = '0; ext_end_next = '0; list_end_next = '0;
      acc_next = '0; left_next = '0; hello_short_next = 1'b0; exts_short_next = 1'b0;
      seen_next = '0; label_next = '0; prev_next = '0; nvalid_next = 1'b1;
      if (32'(mlen) > MAX_MESSAGE_BYTES || mlen == 16'd0) begin
        phase_next = PH_DONE; res_next.done_res = 1'b1; res_next.status = ST_INVALID;
      end else begin
        pos_next = 16'd1;
        if (mlen >= 16'd5 && b == RecordType) begin
          phase_next = PH_REC; left_next = 16'd4;
        end else if (b != HelloType) begin
          phase_next = PH_DONE; res_next.done_res = 1'b1; res_next.status = ST_INVALID;
        end else if (left_in(mlen, 16'd1) < 16'd3) begin
          phase_next = PH_DONE; res_next.done_res = 1'b1; res_next.status = ST_TRUNCATED;
        end else begin
          phase_next = PH_HLEN; left_next = 16'd3;
        end
      end
      res_vld_next = res_next.done_res;
    end else if (phase != PH_IDLE && phase != PH_DONE && pos < msg_end) begin
      pos_next = p1;
      unique case (phase)
        PH_REC: begin
          acc_next = sh; left_next = dec;
          if (dec == 16'd0) begin
            if (n16 > r_msg) begin
              phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
            end else begin
              msg_end_next = p1 + n16;
              if (n16 == 16'd0) begin
                phase_next = PH_DONE; res_next.status = ST_INVALID;
              end else begin
                phase_next = PH_HTYPE; left_next = 16'd1; acc_next = '0;
              end
            end
          end
        end
        PH_HTYPE: begin
          if (b != HelloType) begin
            phase_next = PH_DONE; res_next.status = ST_INVALID;
          end else if (r_msg < 16'd3) begin
            phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
          end else begin
            phase_next = PH_HLEN; left_next = 16'd3; acc_next = '0;
          end
        end
        PH_HLEN: begin
          acc_next = sh; left_next = dec;
          if (dec == 16'd0) begin
            child = (sh < {8'd0, r_msg}) ? sh : {8'd0, r_msg};
            hello_short_next = child < sh;
            if (child == 24'd0 && sh != 24'd0) begin
              phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
            end else begin
              hello_end_next = p1 + child[15:0];
              if (child[15:0] < FixedBytes) begin
                phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
              end else begin
                phase_next = PH_FIXED; left_next = FixedBytes; acc_next = '0;
              end
            end
          end
        end
        PH_FIXED: begin
          left_next = dec;
          if (dec == 16'd0) begin
            if (r_hello < 16'd1) begin
              phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
            end else begin
              phase_next = PH_SIDLEN; left_next = 16'd1; acc_next = '0;
            end
          end
        end
        PH_SIDLEN, PH_SIDSKIP: begin
          if (phase == PH_SIDLEN && r_hello < {8'd0, b}) begin
            phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
          end else if (phase == PH_SIDLEN && b != 8'd0) begin
            phase_next = PH_SIDSKIP; left_next = {8'd0, b}; acc_next = '0;
          end else if (phase == PH_SIDSKIP && dec != 16'd0) begin
            left_next = dec;
          end else if (r_hello < 16'd2) begin
            phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
          end else begin
            phase_next = PH_CSLEN; left_next = 16'd2; acc_next = '0;
          end
        end
        PH_CSLEN: begin
          acc_next = sh; left_next = dec;
          if (dec == 16'd0) begin
            if (n16[0]) begin
              phase_next = PH_DONE; res_next.status = ST_INVALID;
            end else if (r_hello < n16) begin
              phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
            end else if (n16 != 16'd0) begin
              phase_next = PH_CSSKIP; left_next = n16; acc_next = '0;
            end else if (r_hello < 16'd1) begin
              phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
            end else begin
              phase_next = PH_CMLEN; left_next = 16'd1; acc_next = '0;
            end
          end
        end
        PH_CSSKIP: begin
          left_next = dec;
          if (dec == 16'd0) begin
            if (r_hello < 16'd1) begin
              phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
            end else begin
              phase_next = PH_CMLEN; left_next = 16'd1; acc_next = '0;
            end
          end
        end
        PH_CMLEN, PH_CMSKIP: begin
          if (phase == PH_CMLEN && r_hello < {8'd0, b}) begin
            phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
          end else if (phase == PH_CMLEN && b != 8'd0) begin
            phase_next = PH_CMSKIP; left_next = {8'd0, b}; acc_next = '0;
          end else if (phase == PH_CMSKIP && dec != 16'd0) begin
            left_next = dec;
          end else if (r_hello == 16'd0) begin
            phase_next = PH_DONE; res_next.status = ST_NOT_FOUND;
          end else if (r_hello < 16'd2) begin
            phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
          end else begin
            phase_next = PH_EXTSLEN; left_next = 16'd2; acc_next = '0;
          end
        end
        PH_EXTSLEN: begin
          acc_next = sh; left_next = dec;
          if (dec == 16'd0) begin
            child[15:0] = (n16 < r_hello) ? n16 : r_hello;
            exts_short_next = child[15:0] < n16;
            if (child[15:0] == 16'd0 && n16 != 16'd0) begin
              phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
            end else begin
              exts_end_next = p1 + child[15:0];
              // walk check: bytes left equals the clamped length
              if (child[15:0] >= 16'd4) begin
                phase_next = PH_EXTHDR; left_next = 16'd4; acc_next = '0;
              end else begin
                phase_next = PH_DONE;
                res_next.status = (hello_short || exts_short_next) ? ST_TRUNCATED
                                                                   : ST_NOT_FOUND;
              end
            end
          end
        end
        PH_EXTHDR: begin
          // type bytes are ORed together; only a zero type matters
          acc_next = (left > 16'd2) ? {16'd0, acc[7:0] | b} : sh;
          left_next = dec;
          if (dec == 16'd0) begin
            if (n16 > r_exts) begin
              phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
            end else begin
              ext_end_next = p1 + n16;
              if (sh[23:16] == 8'd0) begin
                if (n16 < 16'd2) begin
                  phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
                end else begin
                  phase_next = PH_LISTLEN; left_next = 16'd2; acc_next = '0;
                end
              end else if (n16 != 16'd0) begin
                phase_next = PH_EXTSKIP; left_next = n16; acc_next = '0;
              end else if (r_exts >= 16'd4) begin
                phase_next = PH_EXTHDR; left_next = 16'd4; acc_next = '0;
              end else begin
                phase_next = PH_DONE;
                res_next.status = (hello_short || exts_short) ? ST_TRUNCATED
                                                              : ST_NOT_FOUND;
              end
            end
          end
        end
        PH_EXTSKIP: begin
          left_next = dec;
          if (dec == 16'd0) begin
            if (r_exts >= 16'd4) begin
              phase_next = PH_EXTHDR; left_next = 16'd4; acc_next = '0;
            end else begin
              phase_next = PH_DONE;
              res_next.status = (hello_short || exts_short) ? ST_TRUNCATED : ST_NOT_FOUND;
            end
          end
        end
        PH_LISTLEN: begin
          acc_next = sh; left_next = dec;
          if (dec == 16'd0) begin
            if (r_ext < n16) begin
              phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
            end else begin
              list_end_next = p1 + n16;
              if (n16 >= 16'd3) begin
                phase_next = PH_ENTHDR; left_next = 16'd3; acc_next = '0;
              end else begin
                phase_next = PH_DONE; res_next.status = ST_NOT_FOUND;
              end
            end
          end
        end
        PH_ENTHDR: begin
          acc_next = sh; left_next = dec;
          if (dec == 16'd0) begin
            if (r_list < n16) begin
              phase_next = PH_DONE; res_next.status = ST_TRUNCATED;
            end else if (sh[23:16] == 8'd0) begin
              if (n16 == 16'd0 || 32'(n16) > MAX_HOSTNAME_BYTES) begin
                phase_next = PH_DONE; res_next.status = ST_INVALID;
              end else begin
                phase_next = PH_NAME; left_next = n16; acc_next = '0;
                seen_next = '0; label_next = '0; prev_next = '0; nvalid_next = 1'b1;
              end
            end else if (n16 != 16'd0) begin
              phase_next = PH_ENTSKIP; left_next = n16; acc_next = '0;
            end else if (r_list >= 16'd3) begin
              phase_next = PH_ENTHDR; left_next = 16'd3; acc_next = '0;
            end else begin
              phase_next = PH_DONE; res_next.status = ST_NOT_FOUND;
            end
          end
        end
        PH_ENTSKIP: begin
          left_next = dec;
          if (dec == 16'd0) begin
            if (r_list >= 16'd3) begin
              phase_next = PH_ENTHDR; left_next = 16'd3; acc_next = '0;
            end else begin
              phase_next = PH_DONE; res_next.status = ST_NOT_FOUND;
            end
          end
        end
        PH_NAME: begin
          res_next.name_byte_valid = 1'b1;
          res_next.name_byte = b;
          if (b == ChDot) begin
            if (label == 7'd0 || label > MaxLabelBytes || prev == ChDash) ch_ok = 1'b0;
            lab_n = 7'd0;
          end else begin
            if (!(is_alnum(b) || b == ChDash)) ch_ok = 1'b0;
            if (label == 7'd0 && b == ChDash) ch_ok = 1'b0;
            if (label < 7'd64) lab_n = label + 7'd1;
          end
          label_next = lab_n; prev_next = b; seen_next = seen + 16'd1;
          nvalid_next = ch_ok; left_next = dec;
          if (dec == 16'd0) begin
            last_ok = ch_ok && lab_n != 7'd0 && lab_n <= MaxLabelBytes && b != ChDash;
            nvalid_next = last_ok;
            ch_len = seen_next[7:0];
            phase_next = PH_DONE;
            res_next.status = last_ok ? ST_OK : ST_INVALID;
            res_next.name_length = last_ok ? ch_len : 8'd0;
          end
        end
        default: ;
      endcase
      if (phase_next == PH_DONE) res_next.done_res = 1'b1;
      res_vld_next = res_next.done_res || res_next.name_byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE; pos <= '0; msg_end <= '0; hello_end <= '0; exts_end <= '0;
      ext_end <= '0; list_end <= '0; acc <= '0; left <= '0; hello_short <= 1'b0;
      exts_short <= 1'b0; seen <= '0; label <= '0; prev <= '0; nvalid <= 1'b1;
      res_vld <= 1'b0;
    end else begin
      if (accept) begin
        phase <= phase_next; pos <= pos_next; msg_end <= msg_end_next;
        hello_end <= hello_end_next; exts_end <= exts_end_next; ext_end <= ext_end_next;
        list_end <= list_end_next; acc <= acc_next; left <= left_next;
        hello_short <= hello_short_next; exts_short <= exts_short_next;
        seen <= seen_next; label <= label_next; prev <= prev_next; nvalid <= nvalid_next;
        res_vld <= res_vld_next;
      end else if (m_axis_tready) begin
        res_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) res <= res_next;
  end

`ifndef SYNTH
  a_phase_range: assert property (@(posedge clk) disable iff (rst) phase <= PH_DONE)
    else $error("phase out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped");
  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    accept && res_vld_next && res_next.done_res |=> phase == PH_DONE)
    else $error("status without done phase");
  a_name_in_name: assert property (@(posedge clk) disable iff (rst)
    accept && res_next.name_byte_valid |-> phase == PH_NAME)
    else $error("name byte outside name");
`endif

endmodule
